// ----- design/sip_pkg.sv -----
// ----------------------------------------------------------------------------
// sip_pkg: shared types and constants for the segment intersection pipeline
// Coordinate and fixed point widths, stage widths, the divider tag and the
// final place-and-saturate helper.
// ----------------------------------------------------------------------------
package sip_pkg;

    // coordinate and output formats
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int FIELD_W    = 16;
    localparam int OUT_W      = 24;

    // stream widths
    localparam int S_DATA_W = 8 * FIELD_W;
    localparam int M_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

    // datapath widths
    localparam int DIF_W  = COORD_BITS + 1;       // coordinate difference
    localparam int PRD_W  = 2 * DIF_W;            // difference product
    localparam int AREA_W = PRD_W + 1;            // doubled triangle area
    localparam int A4_W   = AREA_W + 2;           // a3 + a2 - a1
    localparam int DEN_W  = AREA_W + 1;           // a1 - a2, also its magnitude
    localparam int QUO_W  = DIF_W + FRAC_BITS;    // quotient bits before rounding
    localparam int NUM_W  = DEN_W + QUO_W;        // dividend
    localparam int REM_W  = DEN_W + 1;            // shifted partial remainder
    localparam int PNT_W  = COORD_BITS + FRAC_BITS + 3;
    localparam int SAT_W  = (PNT_W > OUT_W + 1) ? PNT_W : OUT_W + 1;
    localparam int DIV_LAT = QUO_W + 1;           // bit stages plus rounding

    localparam logic signed [SAT_W-1:0] OUT_MAX_S = SAT_W'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] OUT_MIN_S = SAT_W'(-(2 ** (OUT_W - 1)));

    // side data that rides along with each division
    typedef struct packed {
        logic                         hit;
        logic                         neg;
        logic signed [COORD_BITS-1:0] start;
    } sip_tag_t;

    // one result item
    typedef struct packed {
        logic                    crosses;
        logic signed [OUT_W-1:0] cross_y;
        logic signed [OUT_W-1:0] cross_x;
    } sip_res_t;

    // start scaled to fixed point plus signed rounded offset, saturated
    function automatic logic signed [OUT_W-1:0] sip_place(input sip_tag_t tag,
                                                          input logic [QUO_W:0] quo);
        logic signed [SAT_W-1:0] base;
        logic signed [SAT_W-1:0] off;
        logic signed [SAT_W-1:0] sum;
        base = SAT_W'(tag.start) <<< FRAC_BITS;
        off  = SAT_W'(signed'({1'b0, quo}));
        if (tag.neg) begin
            off = -off;
        end
        sum = base + off;
        if (sum > OUT_MAX_S) begin
            sum = OUT_MAX_S;
        end else if (sum < OUT_MIN_S) begin
            sum = OUT_MIN_S;
        end
        return sum[OUT_W-1:0];
    endfunction

endpackage

// ----- design/segment_intersection_point.sv -----
// ----------------------------------------------------------------------------
// segment_intersection_point: strict 2D segment crossing test with point
// The item passes 6 area/setup stages, 25 divider bit stages, 1 rounding stage
// and the output register, the first of them loaded at the accepting edge.
// Throughput: one item per cycle while the skid register is empty; the divider
// is fully pipelined, one bit a stage.
// Reset: aresetn clears every stage valid bit and the output and skid valid bits.
// ----------------------------------------------------------------------------
module segment_intersection_point (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y (16 bits each)
    input  logic [sip_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cross_x [23:0], cross_y [47:24]
    output logic [sip_pkg::M_DATA_W-1:0]  m_tdata,
    // crosses
    output logic [0:0]                    m_tuser
);
    import sip_pkg::*;

    localparam int VLD_N = 6 + DIV_LAT;

    // pipeline enable, held off while the skid register is full
    logic en;
    logic vld_reg [VLD_N];

    // input coordinates
    logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, dx, dy;

    // stage 1: differences
    logic signed [DIF_W-1:0] ad_x_reg, ad_y_reg, bd_x_reg, bd_y_reg;
    logic signed [DIF_W-1:0] ac_x_reg, ac_y_reg, bc_x_reg, bc_y_reg;
    logic signed [DIF_W-1:0] ca_x_reg, ca_y_reg, da_x_reg, da_y_reg;
    logic signed [DIF_W-1:0] ab_x_s1_reg, ab_y_s1_reg;
    logic signed [COORD_BITS-1:0] ax_s1_reg, ay_s1_reg;

    // stage 2: products
    logic signed [PRD_W-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg, p3a_reg, p3b_reg;
    logic signed [DIF_W-1:0] ab_x_s2_reg, ab_y_s2_reg;
    logic signed [COORD_BITS-1:0] ax_s2_reg, ay_s2_reg;

    // stage 3: areas
    logic signed [AREA_W-1:0] a1_reg, a2_reg, a3_s3_reg;
    logic signed [DIF_W-1:0] ab_x_s3_reg, ab_y_s3_reg;
    logic signed [COORD_BITS-1:0] ax_s3_reg, ay_s3_reg;

    // stage 4: a4, denominator, first sign test
    logic signed [AREA_W-1:0] a3_s4_reg;
    logic signed [A4_W-1:0]   a4_reg;
    logic signed [DEN_W-1:0]  den_s4_reg;
    logic                     h12_reg;
    logic signed [DIF_W-1:0] ab_x_s4_reg, ab_y_s4_reg;
    logic signed [COORD_BITS-1:0] ax_s4_reg, ay_s4_reg;

    // stage 5: hit decision and magnitudes
    logic                 hit;
    logic [AREA_W-1:0]    a3_abs;
    logic [DEN_W-1:0]     den_abs;
    logic [DIF_W-1:0]     dx_abs, dy_abs;
    logic [AREA_W-1:0]    mag_a3_reg;
    logic [DIF_W-1:0]     mag_dx_reg, mag_dy_reg;
    logic [DEN_W-1:0]     den_s5_reg;
    sip_tag_t             tag_x_s5_reg, tag_y_s5_reg;

    // stage 6: dividends
    logic [AREA_W+DIF_W-1:0] prod_x, prod_y;
    logic [NUM_W-1:0]     num_x_reg, num_y_reg;
    logic [DEN_W-1:0]     den_s6_reg;
    sip_tag_t             tag_x_s6_reg, tag_y_s6_reg;

    // divider outputs
    logic [QUO_W:0]       quo_x, quo_y;
    sip_tag_t             tag_x_out, tag_y_out;
    sip_res_t             tail_res;

    // output register and skid register
    logic                 out_vld_reg;
    sip_res_t             out_res_reg;
    logic                 skid_vld_reg;
    sip_res_t             skid_res_reg;

    assign en       = !skid_vld_reg;
    assign s_tready = en && aresetn;

    assign ax = s_tdata[0*FIELD_W +: COORD_BITS];
    assign ay = s_tdata[1*FIELD_W +: COORD_BITS];
    assign bx = s_tdata[2*FIELD_W +: COORD_BITS];
    assign by = s_tdata[3*FIELD_W +: COORD_BITS];
    assign cx = s_tdata[4*FIELD_W +: COORD_BITS];
    assign cy = s_tdata[5*FIELD_W +: COORD_BITS];
    assign dx = s_tdata[6*FIELD_W +: COORD_BITS];
    assign dy = s_tdata[7*FIELD_W +: COORD_BITS];

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VLD_N; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < VLD_N; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage 1: point differences
    always_ff @(posedge aclk) begin
        if (en) begin
            ad_x_reg    <= DIF_W'(ax) - DIF_W'(dx);
            ad_y_reg    <= DIF_W'(ay) - DIF_W'(dy);
            bd_x_reg    <= DIF_W'(bx) - DIF_W'(dx);
            bd_y_reg    <= DIF_W'(by) - DIF_W'(dy);
            ac_x_reg    <= DIF_W'(ax) - DIF_W'(cx);
            ac_y_reg    <= DIF_W'(ay) - DIF_W'(cy);
            bc_x_reg    <= DIF_W'(bx) - DIF_W'(cx);
            bc_y_reg    <= DIF_W'(by) - DIF_W'(cy);
            ca_x_reg    <= DIF_W'(cx) - DIF_W'(ax);
            ca_y_reg    <= DIF_W'(cy) - DIF_W'(ay);
            da_x_reg    <= DIF_W'(dx) - DIF_W'(ax);
            da_y_reg    <= DIF_W'(dy) - DIF_W'(ay);
            ab_x_s1_reg <= DIF_W'(bx) - DIF_W'(ax);
            ab_y_s1_reg <= DIF_W'(by) - DIF_W'(ay);
            ax_s1_reg   <= ax;
            ay_s1_reg   <= ay;
        end
    end

    // stage 2: cross products
    always_ff @(posedge aclk) begin
        if (en) begin
            p1a_reg     <= PRD_W'(ad_x_reg) * PRD_W'(bd_y_reg);
            p1b_reg     <= PRD_W'(ad_y_reg) * PRD_W'(bd_x_reg);
            p2a_reg     <= PRD_W'(ac_x_reg) * PRD_W'(bc_y_reg);
            p2b_reg     <= PRD_W'(ac_y_reg) * PRD_W'(bc_x_reg);
            p3a_reg     <= PRD_W'(ca_x_reg) * PRD_W'(da_y_reg);
            p3b_reg     <= PRD_W'(ca_y_reg) * PRD_W'(da_x_reg);
            ab_x_s2_reg <= ab_x_s1_reg;
            ab_y_s2_reg <= ab_y_s1_reg;
            ax_s2_reg   <= ax_s1_reg;
            ay_s2_reg   <= ay_s1_reg;
        end
    end

    // stage 3: doubled triangle areas abd, abc, cda
    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg      <= AREA_W'(p1a_reg) - AREA_W'(p1b_reg);
            a2_reg      <= AREA_W'(p2a_reg) - AREA_W'(p2b_reg);
            a3_s3_reg   <= AREA_W'(p3a_reg) - AREA_W'(p3b_reg);
            ab_x_s3_reg <= ab_x_s2_reg;
            ab_y_s3_reg <= ab_y_s2_reg;
            ax_s3_reg   <= ax_s2_reg;
            ay_s3_reg   <= ay_s2_reg;
        end
    end

    // stage 4: fourth area, denominator a3 - a4 = a1 - a2, ab side sign test
    always_ff @(posedge aclk) begin
        if (en) begin
            a3_s4_reg   <= a3_s3_reg;
            a4_reg      <= A4_W'(a3_s3_reg) + A4_W'(a2_reg) - A4_W'(a1_reg);
            den_s4_reg  <= DEN_W'(a1_reg) - DEN_W'(a2_reg);
            h12_reg     <= (a1_reg != '0) && (a2_reg != '0)
                           && (a1_reg[AREA_W-1] != a2_reg[AREA_W-1]);
            ab_x_s4_reg <= ab_x_s3_reg;
            ab_y_s4_reg <= ab_y_s3_reg;
            ax_s4_reg   <= ax_s3_reg;
            ay_s4_reg   <= ay_s3_reg;
        end
    end

    // stage 5: strict crossing, magnitudes and offset signs
    assign hit     = h12_reg && (a3_s4_reg != '0) && (a4_reg != '0)
                     && (a3_s4_reg[AREA_W-1] != a4_reg[A4_W-1]);
    assign a3_abs  = a3_s4_reg[AREA_W-1] ? AREA_W'(-a3_s4_reg) : AREA_W'(a3_s4_reg);
    assign den_abs = den_s4_reg[DEN_W-1] ? DEN_W'(-den_s4_reg) : DEN_W'(den_s4_reg);
    assign dx_abs  = ab_x_s4_reg[DIF_W-1] ? DIF_W'(-ab_x_s4_reg) : DIF_W'(ab_x_s4_reg);
    assign dy_abs  = ab_y_s4_reg[DIF_W-1] ? DIF_W'(-ab_y_s4_reg) : DIF_W'(ab_y_s4_reg);

    // a miss divides zero by one so the point comes out zero
    always_ff @(posedge aclk) begin
        if (en) begin
            mag_a3_reg         <= hit ? a3_abs : '0;
            den_s5_reg         <= hit ? den_abs : DEN_W'(1);
            mag_dx_reg         <= dx_abs;
            mag_dy_reg         <= dy_abs;
            tag_x_s5_reg.hit   <= hit;
            tag_x_s5_reg.neg   <= a3_s4_reg[AREA_W-1] ^ ab_x_s4_reg[DIF_W-1]
                                  ^ den_s4_reg[DEN_W-1];
            tag_x_s5_reg.start <= hit ? ax_s4_reg : '0;
            tag_y_s5_reg.hit   <= hit;
            tag_y_s5_reg.neg   <= a3_s4_reg[AREA_W-1] ^ ab_y_s4_reg[DIF_W-1]
                                  ^ den_s4_reg[DEN_W-1];
            tag_y_s5_reg.start <= hit ? ay_s4_reg : '0;
        end
    end

    // stage 6: dividend |a3| * |delta| scaled to fixed point
    assign prod_x = mag_a3_reg * mag_dx_reg;
    assign prod_y = mag_a3_reg * mag_dy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_x_reg    <= NUM_W'(prod_x) << FRAC_BITS;
            num_y_reg    <= NUM_W'(prod_y) << FRAC_BITS;
            den_s6_reg   <= den_s5_reg;
            tag_x_s6_reg <= tag_x_s5_reg;
            tag_y_s6_reg <= tag_y_s5_reg;
        end
    end

    // one divider per axis
    sip_div u_div_x (
        .aclk    (aclk),
        .en      (en),
        .num_in  (num_x_reg),
        .den_in  (den_s6_reg),
        .tag_in  (tag_x_s6_reg),
        .quo_out (quo_x),
        .tag_out (tag_x_out)
    );

    sip_div u_div_y (
        .aclk    (aclk),
        .en      (en),
        .num_in  (num_y_reg),
        .den_in  (den_s6_reg),
        .tag_in  (tag_y_s6_reg),
        .quo_out (quo_y),
        .tag_out (tag_y_out)
    );

    // final point: start plus signed offset
    assign tail_res.crosses = tag_x_out.hit;
    assign tail_res.cross_x = sip_place(tag_x_out, quo_x);
    assign tail_res.cross_y = sip_place(tag_y_out, quo_y);

    // output register with skid register behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_tready) begin
                out_res_reg  <= skid_res_reg;
                skid_vld_reg <= 1'b0;
            end
        end else if (vld_reg[VLD_N-1]) begin
            if (!out_vld_reg || m_tready) begin
                out_res_reg <= tail_res;
                out_vld_reg <= 1'b1;
            end else begin
                skid_res_reg <= tail_res;
                skid_vld_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_DATA_W'({out_res_reg.cross_y, out_res_reg.cross_x});
    assign m_tuser  = out_res_reg.crosses;

endmodule

// ----- design/sip_div.sv -----
// ----------------------------------------------------------------------------
// sip_div: pipelined restoring divider with round to nearest
// One quotient bit per stage, then a rounding stage; the dividend is known
// to give a quotient below 2^QUO_W, so the remainder starts from its top part.
// ----------------------------------------------------------------------------
module sip_div (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [sip_pkg::NUM_W-1:0]  num_in,
    input  logic [sip_pkg::DEN_W-1:0]  den_in,
    input  sip_pkg::sip_tag_t          tag_in,
    output logic [sip_pkg::QUO_W:0]    quo_out,
    output sip_pkg::sip_tag_t          tag_out
);
    import sip_pkg::*;

    logic [DEN_W-1:0] rem_reg [1:QUO_W];
    logic [QUO_W-1:0] low_reg [1:QUO_W];
    logic [QUO_W-1:0] quo_reg [1:QUO_W];
    logic [DEN_W-1:0] den_reg [1:QUO_W];
    sip_tag_t         tag_reg [1:QUO_W];

    logic [QUO_W:0]   quo_out_reg;
    sip_tag_t         tag_out_reg;

    logic [REM_W-1:0] round_trial;
    logic             round_up;

    // one quotient bit per stage
    for (genvar k = 0; k < QUO_W; k++) begin : g_bit
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W-1:0] den_st;
        sip_tag_t         tag_st;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] diff;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in = num_in[NUM_W-1:QUO_W];
            assign low_in = num_in[QUO_W-1:0];
            assign quo_in = '0;
            assign den_st = den_in;
            assign tag_st = tag_in;
        end else begin : g_next
            assign rem_in = rem_reg[k];
            assign low_in = low_reg[k];
            assign quo_in = quo_reg[k];
            assign den_st = den_reg[k];
            assign tag_st = tag_reg[k];
        end

        // shift in the next dividend bit and try the subtraction
        assign trial = {rem_in, low_in[QUO_W-1]};
        assign diff  = trial - {1'b0, den_st};
        assign take  = (trial >= {1'b0, den_st});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                low_reg[k+1] <= low_in << 1;
                quo_reg[k+1] <= {quo_in[QUO_W-2:0], take};
                den_reg[k+1] <= den_st;
                tag_reg[k+1] <= tag_st;
            end
        end
    end

    // round half up on twice the remainder
    assign round_trial = {rem_reg[QUO_W], 1'b0};
    assign round_up    = (round_trial >= {1'b0, den_reg[QUO_W]});

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_out_reg <= {1'b0, quo_reg[QUO_W]} + (QUO_W + 1)'(round_up);
            tag_out_reg <= tag_reg[QUO_W];
        end
    end

    assign quo_out = quo_out_reg;
    assign tag_out = tag_out_reg;

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stream check of segment_intersection_point
// Feeds segment pairs (directed corner cases, then random pairs that are
// mostly built to cross or to touch) and compares each result item with an
// exact integer prediction of the crossing flag and the fixed point point.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC     = sip_pkg::FRAC_BITS;
    localparam int PT_W     = sip_pkg::OUT_W;
    localparam int N_RANDOM = 850;
    localparam int DRAIN    = 40;
    localparam int WATCHDOG = 2000;

    // one input item, first_start_x in the lowest bits
    typedef struct packed {
        logic signed [15:0] dy;
        logic signed [15:0] dx;
        logic signed [15:0] cy;
        logic signed [15:0] cx;
        logic signed [15:0] by;
        logic signed [15:0] bx;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } seg_pair_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [sip_pkg::S_DATA_W-1:0]   s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [sip_pkg::M_DATA_W-1:0]   m_tdata;
    logic [0:0]                     m_tuser;

    seg_pair_t           pending_pairs[$];
    sip_pkg::sip_res_t   expected_points[$];
    int                  total_items   = 0;
    int                  pairs_taken   = 0;
    int                  points_seen   = 0;
    int                  mismatches    = 0;
    int                  quiet_cycles  = 0;
    logic                pair_taken    = 1'b0;

    segment_intersection_point dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // doubled signed area of triangle p q r
    function automatic longint tri_area2(longint px, longint py, longint qx, longint qy,
                                         longint rx, longint ry);
        return (px - rx) * (qy - ry) - (py - ry) * (qx - rx);
    endfunction

    function automatic bit opposite_signs(longint u, longint v);
        return (u > 0 && v < 0) || (u < 0 && v > 0);
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // start in fixed point plus a3*delta/den rounded half away from zero, saturated
    function automatic logic signed [PT_W-1:0] place_on_axis(longint start, longint stop,
                                                             longint a3, longint den);
        logic [127:0] num;
        logic [127:0] mden;
        logic [127:0] quo;
        logic [127:0] rem;
        longint       delta;
        longint       off;
        longint       pos;
        bit           neg;
        delta = stop - start;
        neg   = (a3 != 0) && (delta != 0) && (den != 0) && ((a3 < 0) ^ (delta < 0) ^ (den < 0));
        num   = 128'(magnitude(a3)) * (128'(magnitude(delta)) << FRAC);
        mden  = 128'(magnitude(den));
        quo   = num / mden;
        rem   = num % mden;
        if (rem >= mden - rem) begin
            quo = quo + 1;
        end
        off = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        pos = start * (longint'(1) << FRAC) + off;
        if (pos > (longint'(1) << (PT_W - 1)) - 1) begin
            pos = (longint'(1) << (PT_W - 1)) - 1;
        end else if (pos < -(longint'(1) << (PT_W - 1))) begin
            pos = -(longint'(1) << (PT_W - 1));
        end
        return pos[PT_W-1:0];
    endfunction

    // strict crossing test and crossing point for one pair
    function automatic sip_pkg::sip_res_t predict_crossing(seg_pair_t p);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint a1, a2, a3, a4;
        sip_pkg::sip_res_t r;
        ax = $signed(p.ax); ay = $signed(p.ay);
        bx = $signed(p.bx); by = $signed(p.by);
        cx = $signed(p.cx); cy = $signed(p.cy);
        dx = $signed(p.dx); dy = $signed(p.dy);
        a1 = tri_area2(ax, ay, bx, by, dx, dy);
        a2 = tri_area2(ax, ay, bx, by, cx, cy);
        a3 = tri_area2(cx, cy, dx, dy, ax, ay);
        a4 = a3 + a2 - a1;
        r = '0;
        if (opposite_signs(a1, a2) && opposite_signs(a3, a4)) begin
            r.crosses = 1'b1;
            r.cross_x = place_on_axis(ax, bx, a3, a3 - a4);
            r.cross_y = place_on_axis(ay, by, a3, a3 - a4);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at item %0d, %s: got %0d, expected %0d",
                 points_seen, what, got, want);
        mismatches++;
    endtask

    task automatic add_pair(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
        seg_pair_t p;
        p.ax = 16'(ax); p.ay = 16'(ay); p.bx = 16'(bx); p.by = 16'(by);
        p.cx = 16'(cx); p.cy = 16'(cy); p.dx = 16'(dx); p.dy = 16'(dy);
        pending_pairs.push_back(p);
    endtask

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // full range coordinate, sometimes one of the corner values
    function automatic int any_coord();
        int corner[5] = '{-32768, 32767, 0, -1, 1};
        if ($urandom_range(7) == 0) begin
            return corner[$urandom_range(4)];
        end
        return span(-32768, 32767);
    endfunction

    task automatic add_random_pair();
        int kind, px, py, ux, uy, vx, vy, ax, ay, bx, by, cx, cy, wx, wy;
        kind = $urandom_range(99);
        if (kind < 45) begin
            // two segments through a common center, crossing unless degenerate
            px = span(-16384, 16383); py = span(-16384, 16383);
            ux = span(-16383, 16383); uy = span(-16383, 16383);
            vx = span(-16383, 16383); vy = span(-16383, 16383);
            add_pair(px - ux, py - uy, px + ux, py + uy, px - vx, py - vy, px + vx, py + vy);
        end else if (kind < 60) begin
            add_pair(any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord(), any_coord(), any_coord());
        end else if (kind < 75) begin
            // tight cluster: many touching, collinear and zero length cases
            px = span(-32000, 32000); py = span(-32000, 32000);
            add_pair(px + span(-3, 3), py + span(-3, 3), px + span(-3, 3), py + span(-3, 3),
                     px + span(-3, 3), py + span(-3, 3), px + span(-3, 3), py + span(-3, 3));
        end else if (kind < 88) begin
            // second segment starts on an endpoint or the midpoint of the first
            ax = span(-8000, 8000); ay = span(-8000, 8000);
            bx = span(-8000, 8000); by = span(-8000, 8000);
            case ($urandom_range(2))
                0: begin cx = ax; cy = ay; end
                1: begin cx = bx; cy = by; end
                default: begin cx = (ax + bx) / 2; cy = (ay + by) / 2; end
            endcase
            add_pair(ax, ay, bx, by, cx, cy, span(-8000, 8000), span(-8000, 8000));
        end else begin
            // shifted copy: parallel, or collinear when the shift lies on the line
            ax = span(-8000, 8000); ay = span(-8000, 8000);
            bx = span(-8000, 8000); by = span(-8000, 8000);
            wx = span(-5, 5); wy = span(-5, 5);
            add_pair(ax, ay, bx, by, ax + wx, ay + wy, bx + wx, by + wy);
        end
    endtask

    // input driver: a new item after each accepted one, with random gaps
    always @(negedge aclk) begin
        int idle_pct;
        if (pairs_taken < total_items / 3) begin
            idle_pct = 9;
        end else if (pairs_taken < 2 * total_items / 3) begin
            idle_pct = 65;
        end else begin
            idle_pct = 0;
        end
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || pair_taken) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_pairs.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        int stall_pct;
        if (points_seen < total_items / 3) begin
            stall_pct = 65;
        end else if (points_seen < 2 * total_items / 3) begin
            stall_pct = 9;
        end else begin
            stall_pct = 0;
        end
        m_tready <= aresetn && ($urandom_range(99) >= stall_pct);
    end

    // monitor: predict on input accept, check on output accept, watchdog
    always @(posedge aclk) begin
        sip_pkg::sip_res_t want;
        pair_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected item, crosses", m_tuser[0], 0);
                end else begin
                    want = expected_points.pop_front();
                    if (m_tuser[0] !== want.crosses) begin
                        report_mismatch("crosses", m_tuser[0], want.crosses);
                    end
                    if (m_tdata[PT_W-1:0] !== want.cross_x) begin
                        report_mismatch("cross_x", $signed(m_tdata[PT_W-1:0]),
                                        $signed(want.cross_x));
                    end
                    if (m_tdata[2*PT_W-1:PT_W] !== want.cross_y) begin
                        report_mismatch("cross_y", $signed(m_tdata[2*PT_W-1:PT_W]),
                                        $signed(want.cross_y));
                    end
                end
                points_seen <= points_seen + 1;
            end
            if (s_tvalid && s_tready) begin
                expected_points.push_back(predict_crossing(seg_pair_t'(s_tdata)));
                pairs_taken <= pairs_taken + 1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG) begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG);
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        // corners of the coordinate range
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        add_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
        add_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        add_pair(-32768, -32768, 32767, 32766, -32768, -32767, 32767, -32768);
        // plain crossings, both orientations
        add_pair(0, 0, 10, 10, 0, 10, 10, 0);
        add_pair(10, 10, 0, 0, 10, 0, 0, 10);
        add_pair(-7, -3, 5, 8, -6, 9, 4, -11);
        // touching, collinear, parallel, disjoint, zero length
        add_pair(0, 0, 10, 0, 5, 0, 5, 10);
        add_pair(0, 0, 10, 0, 10, 0, 10, 10);
        add_pair(0, 0, 10, 0, 5, 0, 15, 0);
        add_pair(0, 0, 10, 0, 0, 1, 10, 1);
        add_pair(0, 0, 1, 1, 5, 0, 6, -3);
        add_pair(0, 0, 10, 0, 5, 1, 5, 10);
        add_pair(3, 3, 3, 3, 0, 0, 6, 6);
        // rounding ties at half a fraction step, both signs
        add_pair(0, 0, 1, 0, 0, -1, 1, 511);
        add_pair(0, 0, -1, 0, 0, -1, -1, 511);
        repeat (N_RANDOM) add_random_pair();
        total_items = pending_pairs.size();

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        while (pairs_taken < total_items || expected_points.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN) @(negedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
